FILE: design/lpt_pkg.sv
// Shared constants and types for the LRU page tracker.
// No dependencies; used by lpt_ctrl and lru_page_tracker_top.
package lpt_pkg;

  // Default configuration
  localparam int CAPACITY_DEF  = 32;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed field widths on the stream ports
  localparam int IN_PAGE_W   = 16;
  localparam int EVICT_W     = 16;
  localparam int OCC_W       = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  // One result item from the sequencer to the output register
  typedef struct packed {
    logic               hit;
    logic               evict_valid;
    logic [EVICT_W-1:0] evict_page;
    logic [OCC_W-1:0]   occupancy;
  } lpt_result_t;

endpackage

FILE: design/lpt_ram.sv
// Single-port-write, single-port-read page store with registered read data.
// No dependencies; instantiated by lru_page_tracker_top.
module lpt_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/lpt_ctrl.sv
// Scan/shift sequencer for the LRU page tracker: one compare unit walks the
// page store one entry a cycle. Depends on lpt_pkg; drives lpt_ram.
module lpt_ctrl #(
  parameter int CAPACITY  = lpt_pkg::CAPACITY_DEF,
  parameter int PAGE_BITS = lpt_pkg::PAGE_BITS_DEF,
  parameter int IDX_W     = $clog2(CAPACITY),
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request side
  input  logic                 start,
  input  logic [PAGE_BITS-1:0] start_page,
  output logic                 idle,
  // result side
  input  logic                 res_ready,
  output logic                 res_valid,
  output lpt_pkg::lpt_result_t res,
  // page store
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_addr,
  input  logic [PAGE_BITS-1:0] rd_data,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [PAGE_BITS-1:0] wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]     iss_r, iss_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 shift_r, shift_nxt;
  logic                 hit_r, hit_nxt;
  logic                 evict_r, evict_nxt;
  logic [PAGE_BITS-1:0] ev_page_r, ev_page_nxt;
  logic                 match;
  logic [CNT_W-1:0]     occ_new;

  assign idle  = (state_r == ST_IDLE);
  assign match = !evict_r && (rd_data == page_r);

  always_comb begin
    state_nxt   = state_r;
    page_nxt    = page_r;
    fill_nxt    = fill_r;
    iss_nxt     = iss_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    shift_nxt   = shift_r;
    hit_nxt     = hit_r;
    evict_nxt   = evict_r;
    ev_page_nxt = ev_page_r;
    rd_en       = 1'b0;
    rd_addr     = iss_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = IDX_W'(rd_idx_r - 1'b1);
    wr_data     = rd_data;
    res_valid   = 1'b0;
    occ_new     = fill_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt  = start_page;
          iss_nxt   = '0;
          shift_nxt = 1'b0;
          hit_nxt   = 1'b0;
          evict_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue side: one read per cycle over the resident entries
        if (iss_r < fill_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt    = iss_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_DONE;
        end
        // data side: compare, then move every later entry down by one
        if (rd_vld_r) begin
          if (shift_r) begin
            wr_en = 1'b1;
          end else if (match) begin
            shift_nxt = 1'b1;
            hit_nxt   = 1'b1;
          end else if (evict_r) begin
            ev_page_nxt = rd_data;
            shift_nxt   = 1'b1;
          end
        end
      end

      ST_DONE: begin
        wr_data = page_r;
        if (shift_r) begin
          // hit or eviction pass: new page goes to the most recent end
          if (res_ready) begin
            wr_en     = 1'b1;
            wr_addr   = IDX_W'(fill_r - 1'b1);
            res_valid = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (fill_r < CNT_W'(CAPACITY)) begin
          if (res_ready) begin
            wr_en     = 1'b1;
            wr_addr   = IDX_W'(fill_r);
            occ_new   = fill_r + 1'b1;
            fill_nxt  = occ_new;
            res_valid = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          // miss on a full set: run a second pass that drops entry zero
          evict_nxt = 1'b1;
          iss_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.hit         = hit_r;
    res.evict_valid = evict_r;
    res.evict_page  = evict_r ? lpt_pkg::EVICT_W'(ev_page_r) : '0;
    res.occupancy   = lpt_pkg::OCC_W'(occ_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      iss_r    <= '0;
      rd_vld_r <= 1'b0;
      shift_r  <= 1'b0;
      hit_r    <= 1'b0;
      evict_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      iss_r    <= iss_nxt;
      rd_vld_r <= rd_vld_nxt;
      shift_r  <= shift_nxt;
      hit_r    <= hit_nxt;
      evict_r  <= evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r    <= page_nxt;
    rd_idx_r  <= rd_idx_nxt;
    ev_page_r <= ev_page_nxt;
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill level above capacity");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (evict_r && !idle) |-> (fill_r == CNT_W'(CAPACITY)))
    else $error("eviction pass with free room");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res.hit && res.evict_valid))
    else $error("result flags both hit and eviction");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CNT_W'(wr_addr) < CNT_W'(CAPACITY)))
    else $error("page store write out of range");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && wr_en) |-> (rd_idx_r != '0))
    else $error("shift write below entry zero");
`endif

endmodule

FILE: design/lru_page_tracker_top.sv
// Top level of the LRU page tracker: stream ports, page store, sequencer and
// output register. Depends on lpt_pkg, lpt_ram and lpt_ctrl.
//
// Keeps up to CAPACITY page numbers in recency order and answers each page
// reference with one result: hit, eviction flag, evicted page and the
// occupancy after the reference. A single comparator walks the page store,
// one entry per cycle, and moves the entries behind a hit down one place
// in the same walk. A miss on a full set adds a second walk that drops the
// oldest page. The page store's single read and single write port set the
// pace of each walk, and a result that cannot leave the output register
// holds the sequencer until it does. The block takes one reference at a
// time; a finished result waits in the output register while the next
// reference is accepted. Page bits above PAGE_BITS are ignored.
module lru_page_tracker_top #(
  parameter int CAPACITY  = lpt_pkg::CAPACITY_DEF,
  parameter int PAGE_BITS = lpt_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [15:0] page
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lpt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [15:0] evict_page, [21:16] occupancy, [23:22] zero
  // out_tuser: [0] hit, [1] evict_valid
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lpt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [lpt_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                 idle;
  logic                 start;
  logic                 res_ready;
  logic                 res_valid;
  lpt_pkg::lpt_result_t res;
  lpt_pkg::lpt_result_t out_r;
  logic                 out_vld_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [PAGE_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [PAGE_BITS-1:0] wr_data;

  assign in_tready = idle;
  assign start     = in_tvalid && idle;
  assign res_ready = !out_vld_r || out_tready;

  lpt_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (PAGE_BITS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lpt_ctrl #(
    .CAPACITY  (CAPACITY),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_page (PAGE_BITS'(in_tdata[lpt_pkg::IN_PAGE_W-1:0])),
    .idle       (idle),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // Output register: hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_r.occupancy, out_r.evict_page};
  assign out_tuser  = {out_r.evict_valid, out_r.hit};

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for lru_page_tracker_top: streams page references,
// tracks LRU order in a shadow list and checks every result transfer.
// Depends on lpt_pkg and the design sources under design/.
`timescale 1ns / 100ps

class lru_shadow;
  localparam int CAP = lpt_pkg::CAPACITY_DEF;
  localparam int PB  = lpt_pkg::PAGE_BITS_DEF;

  logic [PB-1:0]       lru_order[$];     // index 0 is least recently used
  lpt_pkg::lpt_result_t pending_results[$];
  int fail_count;
  int hit_count;
  int evict_count;
  int result_count;

  function new();
    fail_count   = 0;
    hit_count    = 0;
    evict_count  = 0;
    result_count = 0;
  endfunction

  // Predict the result of one accepted reference and queue it.
  function void reference_page(logic [lpt_pkg::IN_PAGE_W-1:0] raw);
    logic [PB-1:0]        pg;
    lpt_pkg::lpt_result_t res;
    int                   idx;
    pg  = raw[PB-1:0];
    res = '0;
    idx = -1;
    foreach (lru_order[i]) begin
      if (idx < 0 && lru_order[i] == pg) idx = i;
    end
    if (idx >= 0) begin
      res.hit = 1'b1;
      lru_order.delete(idx);
    end else if (lru_order.size() >= CAP) begin
      res.evict_valid = 1'b1;
      res.evict_page  = lpt_pkg::EVICT_W'(lru_order.pop_front());
    end
    lru_order.push_back(pg);
    res.occupancy = lpt_pkg::OCC_W'(lru_order.size());
    pending_results.push_back(res);
  endfunction

  function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function void check_result(logic [lpt_pkg::OUT_TDATA_W-1:0] tdata,
                             logic [lpt_pkg::OUT_TUSER_W-1:0] tuser);
    lpt_pkg::lpt_result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("result transfer with no reference outstanding: tdata 0x%0h tuser 0x%0h",
             tdata, tuser);
      fail_count++;
      return;
    end
    exp_r = pending_results.pop_front();
    result_count++;
    if (exp_r.hit) hit_count++;
    if (exp_r.evict_valid) evict_count++;
    compare_field("hit", exp_r.hit, tuser[0]);
    compare_field("evict_valid", exp_r.evict_valid, tuser[1]);
    compare_field("evict_page", exp_r.evict_page, tdata[15:0]);
    compare_field("occupancy", exp_r.occupancy, tdata[21:16]);
    compare_field("tdata_pad", 0, tdata[23:22]);
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int NUM_REFS      = 1800;
  localparam int DRAIN_CYCLES  = 2 * lpt_pkg::CAPACITY_DEF + 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 300;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [lpt_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lpt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [lpt_pkg::OUT_TUSER_W-1:0] out_tuser;

  lru_shadow shadow = new();
  int        cycle_count = 0;
  int        refs_sent = 0;
  int        tx_gap_pct = 0;
  int        rx_stall_pct = 0;
  bit        hold_done = 1'b0;

  lru_page_tracker_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, shadow.pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_page(logic [lpt_pkg::IN_PAGE_W-1:0] pg);
    int gap;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.reference_page(pg);
    refs_sent++;
  endtask

  // Result side: check each transfer, then choose the next tready.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) shadow.check_result(out_tdata, out_tuser);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && shadow.result_count >= HOLD_AFTER) begin
        // long hold-off so the block fills up and stalls its input
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        stall_left = pick_gap(rx_stall_pct);
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    logic [15:0] directed_pages[$];
    logic [15:0] base;
    int          pool;
    int          phase_len;
    int          pcts[3];
    pcts = '{0, 20, 50};
    directed_pages = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                       16'h5555, 16'hAAAA, 16'h5555, 16'h8000, 16'h0001,
                       16'h7FFF, 16'hAAAA, 16'hAAAA, 16'hFFFF};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set, hit on the sole page, hits on the MRU and LRU ends, extremes
    foreach (directed_pages[i]) send_page(directed_pages[i]);

    // fill past capacity with distinct pages so the oldest get evicted
    for (int i = 0; i < lpt_pkg::CAPACITY_DEF + 8; i++) send_page(16'h0100 + 16'(i));

    while (refs_sent < NUM_REFS) begin
      tx_gap_pct   = pcts[$urandom_range(0, 2)];
      rx_stall_pct = pcts[$urandom_range(0, 2)];
      case ($urandom_range(0, 7))
        0:       pool = 1;
        1:       pool = $urandom_range(2, 8);
        default: pool = $urandom_range(20, 48);
      endcase
      case ($urandom_range(0, 3))
        0:       base = 16'h0000;
        1:       base = 16'(16'hFFFF - pool + 1);
        default: base = 16'($urandom_range(0, 16'hFFFF - pool + 1));
      endcase
      phase_len = $urandom_range(50, 150);
      for (int i = 0; i < phase_len; i++) begin
        // mostly a working set around base, some full-range noise
        if ($urandom_range(0, 9) == 0) send_page(16'($urandom()));
        else send_page(16'(base + $urandom_range(0, pool - 1)));
      end
    end
    in_tvalid <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d page references: %0d hits, %0d evictions",
             shadow.result_count, shadow.hit_count, shadow.evict_count);
    $display("covered sole-page hits, MRU/LRU hits, full-set misses and stalls");
    if (shadow.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
